FILE: rtl/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// shared widths, word types and the divider lane word for the segment pair
// intersection pipeline
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int FIELD_W = 32;
  localparam int COORD_W = 32;
  // coordinate bits actually used from each field
  localparam int IN_W    = (COORD_W < FIELD_W) ? COORD_W : FIELD_W;
  localparam int DIFF_W  = IN_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SGN_W   = PROD_W + 1;
  // magnitude of a normalized cross product
  localparam int MAG_W   = 2 * IN_W + 1;
  localparam int CHUNK_W = (MAG_W + 2) / 3;
  localparam int PAD_W   = 3 * CHUNK_W;
  localparam int PP_W    = CHUNK_W + IN_W;
  localparam int NUM_W   = MAG_W + IN_W;
  localparam int BASE_W  = IN_W + 2;
  // front stages, one stage per quotient bit, round stage, output register
  localparam int FRONT_N = 6;
  localparam int NSTG    = FRONT_N + IN_W + 2;

  typedef struct packed {
    logic [FIELD_W-1:0] first_start_x;
    logic [FIELD_W-1:0] first_start_y;
    logic [FIELD_W-1:0] first_end_x;
    logic [FIELD_W-1:0] first_end_y;
    logic [FIELD_W-1:0] second_start_x;
    logic [FIELD_W-1:0] second_start_y;
    logic [FIELD_W-1:0] second_end_x;
    logic [FIELD_W-1:0] second_end_y;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] cross_x;
    logic [FIELD_W-1:0] cross_y;
  } out_word_t;

  typedef struct packed {
    logic                   hit;
    logic [MAG_W-1:0]       den;
    logic [NUM_W-1:0]       rem_x;
    logic [NUM_W-1:0]       rem_y;
    logic [IN_W-1:0]        quo_x;
    logic [IN_W-1:0]        quo_y;
    logic                   neg_x;
    logic                   neg_y;
    logic signed [IN_W-1:0] x1;
    logic signed [IN_W-1:0] y1;
  } div_t;

  function automatic logic signed [IN_W-1:0] coord(input logic [FIELD_W-1:0] f);
    coord = $signed(f[IN_W-1:0]);
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff(input logic signed [IN_W-1:0] a,
                                                    input logic signed [IN_W-1:0] b);
    diff = DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

FILE: rtl/segment_pair_intersection.sv
// throughput: one word per cycle; each stage holds a word until the next one frees up
// the quotient takes one restoring step per bit, one register stage each
// reset: asynchronous active low, clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// segment_pair_intersection
// intersection point of two segments, exact integer math, rounded half away
// from zero
// ----------------------------------------------------------------------------
module segment_pair_intersection (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  sip_pkg::in_word_t in_word_i,
  output logic              valid_o,
  input  logic              stall_i,
  output sip_pkg::out_word_t out_word_o
);
  import sip_pkg::*;

  // stage valid bits and per stage advance; a stage moves when it is empty or
  // the stage after it moves, so bubbles collapse under a stalled output
  logic [NSTG-1:0] v_q, v_d, en, v_in;

  assign en[NSTG-1] = !v_q[NSTG-1] || !stall_i;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign v_in = {v_q[NSTG-2:0], valid_i};
  assign v_d  = (v_in & en) | (v_q & ~en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en[0];

  // stage 1: direction and offset vectors
  logic signed [DIFF_W-1:0] dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q;
  logic signed [IN_W-1:0]   x1_1q, y1_1q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x1_1q <= coord(in_word_i.first_start_x);
      y1_1q <= coord(in_word_i.first_start_y);
      dx1_q <= diff(coord(in_word_i.first_end_x), coord(in_word_i.first_start_x));
      dy1_q <= diff(coord(in_word_i.first_end_y), coord(in_word_i.first_start_y));
      dx2_q <= diff(coord(in_word_i.second_end_x), coord(in_word_i.second_start_x));
      dy2_q <= diff(coord(in_word_i.second_end_y), coord(in_word_i.second_start_y));
      dx3_q <= diff(coord(in_word_i.second_start_x), coord(in_word_i.first_start_x));
      dy3_q <= diff(coord(in_word_i.second_start_y), coord(in_word_i.first_start_y));
    end
  end

  // stage 2: six cross product terms
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [DIFF_W-1:0] dx1_2q, dy1_2q;
  logic signed [IN_W-1:0]   x1_2q, y1_2q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pa_q   <= PROD_W'(dx1_q) * PROD_W'(dy2_q);
      pb_q   <= PROD_W'(dy1_q) * PROD_W'(dx2_q);
      pc_q   <= PROD_W'(dx3_q) * PROD_W'(dy2_q);
      pd_q   <= PROD_W'(dy3_q) * PROD_W'(dx2_q);
      pe_q   <= PROD_W'(dx3_q) * PROD_W'(dy1_q);
      pf_q   <= PROD_W'(dy3_q) * PROD_W'(dx1_q);
      dx1_2q <= dx1_q;
      dy1_2q <= dy1_q;
      x1_2q  <= x1_1q;
      y1_2q  <= y1_1q;
    end
  end

  // stage 3: denominator and both parameter numerators
  logic signed [SGN_W-1:0]  den_3q, tn_3q, un_3q;
  logic signed [DIFF_W-1:0] dx1_3q, dy1_3q;
  logic signed [IN_W-1:0]   x1_3q, y1_3q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      den_3q <= SGN_W'(pa_q) - SGN_W'(pb_q);
      tn_3q  <= SGN_W'(pc_q) - SGN_W'(pd_q);
      un_3q  <= SGN_W'(pe_q) - SGN_W'(pf_q);
      dx1_3q <= dx1_2q;
      dy1_3q <= dy1_2q;
      x1_3q  <= x1_2q;
      y1_3q  <= y1_2q;
    end
  end

  // stage 4: flip signs so the denominator is never negative, direction magnitudes
  logic signed [SGN_W-1:0] den_4q, tn_4q, un_4q;
  logic [IN_W-1:0]         adx_4q, ady_4q;
  logic                    sx_4q, sy_4q;
  logic signed [IN_W-1:0]  x1_4q, y1_4q;
  logic signed [DIFF_W-1:0] ndx, ndy;

  assign ndx = -dx1_3q;
  assign ndy = -dy1_3q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      den_4q <= den_3q[SGN_W-1] ? -den_3q : den_3q;
      tn_4q  <= den_3q[SGN_W-1] ? -tn_3q : tn_3q;
      un_4q  <= den_3q[SGN_W-1] ? -un_3q : un_3q;
      sx_4q  <= dx1_3q[DIFF_W-1];
      sy_4q  <= dy1_3q[DIFF_W-1];
      adx_4q <= dx1_3q[DIFF_W-1] ? ndx[IN_W-1:0] : dx1_3q[IN_W-1:0];
      ady_4q <= dy1_3q[DIFF_W-1] ? ndy[IN_W-1:0] : dy1_3q[IN_W-1:0];
      x1_4q  <= x1_3q;
      y1_4q  <= y1_3q;
    end
  end

  // stage 5: hit test and partial products of t numerator times direction
  logic [PAD_W-1:0]       tn_pad;
  logic                   hit_5q;
  logic [MAG_W-1:0]       den_5q;
  logic [PP_W-1:0]        ppx_q [3];
  logic [PP_W-1:0]        ppy_q [3];
  logic                   sx_5q, sy_5q;
  logic signed [IN_W-1:0] x1_5q, y1_5q;

  assign tn_pad = PAD_W'(tn_4q[MAG_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      hit_5q <= (den_4q != '0) && !tn_4q[SGN_W-1] && (tn_4q <= den_4q)
                && !un_4q[SGN_W-1] && (un_4q <= den_4q);
      den_5q <= den_4q[MAG_W-1:0];
      for (int k = 0; k < 3; k++) begin
        ppx_q[k] <= PP_W'(tn_pad[k*CHUNK_W +: CHUNK_W]) * PP_W'(adx_4q);
        ppy_q[k] <= PP_W'(tn_pad[k*CHUNK_W +: CHUNK_W]) * PP_W'(ady_4q);
      end
      sx_5q <= sx_4q;
      sy_5q <= sy_4q;
      x1_5q <= x1_4q;
      y1_5q <= y1_4q;
    end
  end

  // stage 6: full numerators, start of the divider lanes
  div_t div_q [IN_W+1];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      div_q[0].hit   <= hit_5q;
      div_q[0].den   <= den_5q;
      div_q[0].rem_x <= NUM_W'(ppx_q[0]) + (NUM_W'(ppx_q[1]) << CHUNK_W)
                        + (NUM_W'(ppx_q[2]) << (2 * CHUNK_W));
      div_q[0].rem_y <= NUM_W'(ppy_q[0]) + (NUM_W'(ppy_q[1]) << CHUNK_W)
                        + (NUM_W'(ppy_q[2]) << (2 * CHUNK_W));
      div_q[0].quo_x <= '0;
      div_q[0].quo_y <= '0;
      div_q[0].neg_x <= sx_5q;
      div_q[0].neg_y <= sy_5q;
      div_q[0].x1    <= x1_5q;
      div_q[0].y1    <= y1_5q;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < IN_W; i++) begin : g_div
    sip_div_step u_step (
      .clk_i  (clk_i),
      .en_i   (en[FRONT_N+i]),
      .data_i (div_q[i]),
      .data_o (div_q[i+1])
    );
  end

  // round stage: base point plus or minus the quotient, remainder against half
  div_t                    dv;
  logic [MAG_W-1:0]        rx, ry;
  logic signed [BASE_W-1:0] qx_s, qy_s;
  logic signed [BASE_W-1:0] bx_q, by_q;
  logic                    gtx_q, eqx_q, gty_q, eqy_q, nx_q, ny_q, hit_rq;

  assign dv   = div_q[IN_W];
  assign rx   = dv.rem_x[NUM_W-1:IN_W];
  assign ry   = dv.rem_y[NUM_W-1:IN_W];
  assign qx_s = dv.neg_x ? -$signed(BASE_W'(dv.quo_x)) : $signed(BASE_W'(dv.quo_x));
  assign qy_s = dv.neg_y ? -$signed(BASE_W'(dv.quo_y)) : $signed(BASE_W'(dv.quo_y));

  always_ff @(posedge clk_i) begin
    if (en[NSTG-2]) begin
      hit_rq <= dv.hit;
      bx_q   <= BASE_W'(dv.x1) + qx_s;
      by_q   <= BASE_W'(dv.y1) + qy_s;
      gtx_q  <= {rx, 1'b0} > {1'b0, dv.den};
      eqx_q  <= {rx, 1'b0} == {1'b0, dv.den};
      gty_q  <= {ry, 1'b0} > {1'b0, dv.den};
      eqy_q  <= {ry, 1'b0} == {1'b0, dv.den};
      nx_q   <= dv.neg_x;
      ny_q   <= dv.neg_y;
    end
  end

  // ties go away from zero: the sign of the exact point picks the direction
  function automatic logic signed [BASE_W-1:0] round_fix(
      input logic signed [BASE_W-1:0] b, input logic gt, input logic eq,
      input logic neg);
    logic signed [BASE_W-1:0] up, dn;
    up = b + BASE_W'(1);
    dn = b - BASE_W'(1);
    priority if (gt) begin
      round_fix = neg ? dn : up;
    end else if (eq && neg) begin
      round_fix = (b <= 0) ? dn : b;
    end else if (eq) begin
      round_fix = (b >= 0) ? up : b;
    end else begin
      round_fix = b;
    end
  endfunction

  logic signed [BASE_W-1:0] fx, fy;
  logic signed [IN_W-1:0]   fx_c, fy_c;
  out_word_t                out_q;

  assign fx   = round_fix(bx_q, gtx_q, eqx_q, nx_q);
  assign fy   = round_fix(by_q, gty_q, eqy_q, ny_q);
  assign fx_c = fx[IN_W-1:0];
  assign fy_c = fy[IN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      out_q.hit     <= hit_rq;
      out_q.cross_x <= hit_rq ? FIELD_W'(fx_c) : '0;
      out_q.cross_y <= hit_rq ? FIELD_W'(fy_c) : '0;
    end
  end

  assign valid_o    = v_q[NSTG-1];
  assign out_word_o = out_q;

`ifndef SYNTHESIS
  // a word without a hit carries a zero point
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_word_o.hit) |-> (out_word_o.cross_x == '0 && out_word_o.cross_y == '0))
    else $error("no-hit word with nonzero point");
  // an empty first stage always takes a word
  a_take_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> !stall_o)
    else $error("stall with a free first stage");
  // back pressure only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q && stall_i))
    else $error("stall with a bubble in the pipeline");
  // a held output word stays in the last stage
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(out_word_o)))
    else $error("stalled output word lost");
`endif

endmodule

FILE: rtl/sip_div_step.sv
// ----------------------------------------------------------------------------
// sip_div_step
// one restoring division step for both lanes, registered
// ----------------------------------------------------------------------------
module sip_div_step (
  input  logic         clk_i,
  input  logic         en_i,
  input  sip_pkg::div_t data_i,
  output sip_pkg::div_t data_o
);
  import sip_pkg::*;

  logic [MAG_W:0]   hi_x, hi_y, dx_w, dy_w, den_e;
  logic             ge_x, ge_y;
  logic [MAG_W-1:0] hn_x, hn_y;
  div_t             data_d, data_q;

  always_comb begin
    den_e  = {1'b0, data_i.den};
    hi_x   = data_i.rem_x[NUM_W-1:IN_W-1];
    hi_y   = data_i.rem_y[NUM_W-1:IN_W-1];
    ge_x   = hi_x >= den_e;
    ge_y   = hi_y >= den_e;
    dx_w   = hi_x - den_e;
    dy_w   = hi_y - den_e;
    hn_x   = ge_x ? dx_w[MAG_W-1:0] : hi_x[MAG_W-1:0];
    hn_y   = ge_y ? dy_w[MAG_W-1:0] : hi_y[MAG_W-1:0];
    data_d = data_i;
    data_d.rem_x = {hn_x, data_i.rem_x[IN_W-2:0], 1'b0};
    data_d.rem_y = {hn_y, data_i.rem_y[IN_W-2:0], 1'b0};
    data_d.quo_x = {data_i.quo_x[IN_W-2:0], ge_x};
    data_d.quo_y = {data_i.quo_y[IN_W-2:0], ge_y};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
